// ===== rtl/core/pkss_pkg.sv =====
package pkss_pkg;

  localparam int LEN_W       = 17;
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int GAIN_SHIFT  = 17;
  localparam int DLEN_W      = 13;
  localparam int ELEN_W      = 12;
  localparam int EXC_POS_W   = 12;
  localparam int EXC_IDX_W   = 11;
  localparam int EXC_VAL_LSB = EXC_IDX_W;
  localparam int IN_DATA_W   = 32;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int USER_REQ_BIT   = 0;
  localparam int USER_PLUCK_BIT = 1;

  localparam logic [DLEN_W-1:0] DLEN_RESET = 13'd100;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd65143;
  localparam logic [ELEN_W-1:0] ELEN_RESET = 12'd2000;
  localparam logic [LEN_W-1:0]  DLEN_MIN   = 17'd2;
  localparam logic [LEN_W-1:0]  ELEN_MIN   = 17'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH  = 2'd0,
    CFG_FEEDBACK_GAIN = 2'd1,
    CFG_EXC_LENGTH    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== rtl/core/pkss_delay_line.sv =====
module pkss_delay_line #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  pkss_pkg::sample_t wr_data,
  output pkss_pkg::sample_t tap_a,
  output pkss_pkg::sample_t tap_b
);

  pkss_pkg::sample_t mem [DEPTH];
  pkss_pkg::sample_t q_a_r;
  pkss_pkg::sample_t q_b_r;
  pkss_pkg::sample_t fwd_data_r;
  logic [AW:0]       fill_r;
  logic              ok_a_r;
  logic              ok_b_r;
  logic              fwd_a_r;
  logic              fwd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_a_r      <= mem[rd_addr_a];
      q_b_r      <= mem[rd_addr_b];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      ok_a_r  <= 1'b0;
      ok_b_r  <= 1'b0;
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else begin
      if (wr_en && ({1'b0, wr_addr} == fill_r)) begin
        fill_r <= fill_r + 1'b1;
      end
      if (rd_en) begin
        ok_a_r  <= {1'b0, rd_addr_a} < fill_r;
        ok_b_r  <= {1'b0, rd_addr_b} < fill_r;
        fwd_a_r <= wr_en && (wr_addr == rd_addr_a);
        fwd_b_r <= wr_en && (wr_addr == rd_addr_b);
      end
    end
  end

  assign tap_a = fwd_a_r ? fwd_data_r : (ok_a_r ? q_a_r : '0);
  assign tap_b = fwd_b_r ? fwd_data_r : (ok_b_r ? q_b_r : '0);

endmodule

// ===== rtl/core/pkss_exc_table.sv =====
module pkss_exc_table #(
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  pkss_pkg::sample_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output pkss_pkg::sample_t rd_data
);

  pkss_pkg::sample_t mem [DEPTH];
  pkss_pkg::sample_t q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule

// ===== rtl/core/pkss_loop_calc.sv =====
module pkss_loop_calc (
  input  pkss_pkg::sample_t               tap_a,
  input  pkss_pkg::sample_t               tap_b,
  input  logic [pkss_pkg::GAIN_W-1:0]     gain,
  input  logic                            feed,
  input  pkss_pkg::sample_t               exc_word,
  output pkss_pkg::sample_t               sample,
  output pkss_pkg::sample_t               store_word
);

  localparam int SW   = pkss_pkg::SAMPLE_W;
  localparam int PW   = SW + pkss_pkg::GAIN_W + 2;
  localparam int SCW  = PW - pkss_pkg::GAIN_SHIFT;

  function automatic pkss_pkg::sample_t sat(input logic signed [SW:0] v);
    pkss_pkg::sample_t r;
    if (v[SW] != v[SW-1]) begin
      r = v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  logic signed [SW:0]    tap_sum;
  logic signed [PW-1:0]  prod;
  logic signed [SCW-1:0] scaled;
  logic signed [SW:0]    exc_in;
  logic signed [SW:0]    mix;

  always_comb begin
    tap_sum    = $signed({tap_a[SW-1], tap_a}) + $signed({tap_b[SW-1], tap_b});
    prod       = tap_sum * $signed({1'b0, gain});
    scaled     = prod[PW-1:pkss_pkg::GAIN_SHIFT];
    sample     = sat(scaled[SW:0]);
    exc_in     = feed ? $signed({exc_word[SW-1], exc_word}) : '0;
    mix        = $signed({sample[SW-1], sample}) + exc_in;
    store_word = sat(mix);
  end

endmodule

// ===== rtl/core/plucked_string_synth.sv =====
// Karplus-Strong plucked string voice. Each input word is a tick (one output sample) or a load
// (one excitation table word, no output); words are accepted at one per cycle unless a tick
// held in the first stage waits on a stalled output. A tick's taps are registered on acceptance,
// and its sample is then registered in the output register. The delay line sits in a memory
// with two read ports and one write port: a tick reads both taps when accepted and writes the
// new loop value back as its sample enters the output register, with a forward path for the
// case where the following tick reads that same entry. A fill count marks which delay entries
// have been written, so unwritten entries read as zero and no clearing pass runs after reset.
// A configuration write must only happen while no tick is in flight; cfg_ready is always high.
module plucked_string_synth #(
  parameter int DELAY_DEPTH = 4096,
  parameter int EXC_DEPTH   = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pkss_pkg::IN_DATA_W-1:0]      in_tdata,   // exc_index, exc_value
  input  logic [pkss_pkg::IN_USER_W-1:0]      in_tuser,   // req_type, pluck
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pkss_pkg::OUT_DATA_W-1:0]     out_tdata,  // sample
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pkss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pkss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LW  = pkss_pkg::LEN_W;
  localparam int DAW = $clog2(DELAY_DEPTH);
  localparam int EAW = (EXC_DEPTH > 1) ? $clog2(EXC_DEPTH) : 1;
  localparam int EPW = pkss_pkg::EXC_POS_W;
  localparam logic [LW-1:0] DEPTH_LEN = LW'(DELAY_DEPTH);
  localparam logic [LW-1:0] EXC_LEN   = LW'(EXC_DEPTH);

  function automatic logic [LW-1:0] clamp_dlen(input logic [pkss_pkg::DLEN_W-1:0] v);
    logic [LW-1:0] n;
    n = LW'(v);
    if (n < pkss_pkg::DLEN_MIN) begin
      n = pkss_pkg::DLEN_MIN;
    end else if (n > DEPTH_LEN) begin
      n = DEPTH_LEN;
    end
    return n;
  endfunction

  function automatic logic [LW-1:0] clamp_elen(input logic [pkss_pkg::ELEN_W-1:0] v);
    logic [LW-1:0] n;
    n = LW'(v);
    if (n < pkss_pkg::ELEN_MIN) begin
      n = pkss_pkg::ELEN_MIN;
    end else if (n > EXC_LEN) begin
      n = EXC_LEN;
    end
    return n;
  endfunction

  logic [pkss_pkg::DLEN_W-1:0] dlen_r;
  logic [pkss_pkg::GAIN_W-1:0] gain_r;
  logic [pkss_pkg::ELEN_W-1:0] elen_r;
  logic [DAW-1:0]              wp_r;
  logic [DAW-1:0]              wp_nxt;
  logic [EPW-1:0]              exc_pos_r;
  logic [EPW-1:0]              exc_pos_nxt;
  logic                        plucking_r;
  logic                        plucking_nxt;
  logic                        s1_valid_r;
  logic                        s1_feed_r;
  logic [DAW-1:0]              s1_waddr_r;
  logic                        out_valid_r;
  pkss_pkg::sample_t           out_sample_r;

  logic [LW-1:0]   dlen_eff;
  logic [LW-1:0]   elen_eff;
  logic [LW-1:0]   dlen_new;
  logic [LW-1:0]   wp_inc;
  logic [DAW-1:0]  nxt_addr;
  logic [EPW-1:0]  ep;
  logic [EPW-1:0]  ep1;
  logic            feed;
  logic            in_take;
  logic            tick_take;
  logic            load_take;
  logic            out_take;
  logic            s1_adv;
  logic            exc_we;

  pkss_pkg::sample_t tap_a;
  pkss_pkg::sample_t tap_b;
  pkss_pkg::sample_t exc_word;
  pkss_pkg::sample_t sample;
  pkss_pkg::sample_t store_word;

  assign cfg_ready = 1'b1;
  assign out_take  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_take;
  assign in_tready = !s1_valid_r || out_take;
  assign in_take   = in_tvalid && in_tready;
  assign tick_take = in_take && (in_tuser[pkss_pkg::USER_REQ_BIT] == pkss_pkg::REQ_TICK);
  assign load_take = in_take && (in_tuser[pkss_pkg::USER_REQ_BIT] == pkss_pkg::REQ_LOAD);
  assign exc_we    = load_take && (LW'(in_tdata[pkss_pkg::EXC_IDX_W-1:0]) < EXC_LEN);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;

  always_comb begin
    dlen_eff     = clamp_dlen(dlen_r);
    elen_eff     = clamp_elen(elen_r);
    dlen_new     = clamp_dlen(cfg_data[pkss_pkg::DLEN_W-1:0]);
    wp_inc       = LW'(wp_r) + 1'b1;
    nxt_addr     = (wp_inc >= dlen_eff) ? '0 : wp_inc[DAW-1:0];
    ep           = in_tuser[pkss_pkg::USER_PLUCK_BIT] ? '0 : exc_pos_r;
    ep1          = ep + 1'b1;
    feed         = 1'b0;
    wp_nxt       = wp_r;
    exc_pos_nxt  = exc_pos_r;
    plucking_nxt = plucking_r;
    if (tick_take) begin
      wp_nxt = nxt_addr;
      if (plucking_r || in_tuser[pkss_pkg::USER_PLUCK_BIT]) begin
        exc_pos_nxt = ep;
        if (LW'(ep) >= elen_eff) begin
          plucking_nxt = 1'b0;
        end else begin
          feed         = 1'b1;
          exc_pos_nxt  = ep1;
          plucking_nxt = !((LW'(ep1) >= elen_eff) || (LW'(ep1) >= dlen_eff));
        end
      end
    end
    if (cfg_valid && (cfg_index == pkss_pkg::CFG_DELAY_LENGTH) && (LW'(wp_r) >= dlen_new)) begin
      wp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlen_r <= pkss_pkg::DLEN_RESET;
      gain_r <= pkss_pkg::GAIN_RESET;
      elen_r <= pkss_pkg::ELEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pkss_pkg::CFG_DELAY_LENGTH:  dlen_r <= cfg_data[pkss_pkg::DLEN_W-1:0];
        pkss_pkg::CFG_FEEDBACK_GAIN: gain_r <= cfg_data[pkss_pkg::GAIN_W-1:0];
        pkss_pkg::CFG_EXC_LENGTH:    elen_r <= cfg_data[pkss_pkg::ELEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      exc_pos_r   <= '0;
      plucking_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      exc_pos_r  <= exc_pos_nxt;
      plucking_r <= plucking_nxt;
      if (tick_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      s1_feed_r  <= feed;
      s1_waddr_r <= wp_r;
    end
    if (s1_adv) begin
      out_sample_r <= sample;
    end
  end

  pkss_delay_line #(
    .DEPTH (DELAY_DEPTH)
  ) u_delay (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (tick_take),
    .rd_addr_a (wp_r),
    .rd_addr_b (nxt_addr),
    .wr_en     (s1_adv),
    .wr_addr   (s1_waddr_r),
    .wr_data   (store_word),
    .tap_a     (tap_a),
    .tap_b     (tap_b)
  );

  pkss_exc_table #(
    .DEPTH (EXC_DEPTH)
  ) u_exc (
    .clk     (clk),
    .wr_en   (exc_we),
    .wr_addr (EAW'(in_tdata[pkss_pkg::EXC_IDX_W-1:0])),
    .wr_data (in_tdata[pkss_pkg::EXC_VAL_LSB +: pkss_pkg::SAMPLE_W]),
    .rd_en   (feed),
    .rd_addr (EAW'(ep)),
    .rd_data (exc_word)
  );

  pkss_loop_calc u_calc (
    .tap_a      (tap_a),
    .tap_b      (tap_b),
    .gain       (gain_r),
    .feed       (s1_feed_r),
    .exc_word   (exc_word),
    .sample     (sample),
    .store_word (store_word)
  );

endmodule

// ===== rtl/core/pkss_checker.sv =====
module pkss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [pkss_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pkss_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic tick_word;

  assign tick_word = in_tvalid && in_tready &&
                     (in_tuser[pkss_pkg::USER_REQ_BIT] == pkss_pkg::REQ_TICK);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a blocked output");

  a_sample_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(tick_word, 2))
    else $error("output word without a tick");

endmodule

bind plucked_string_synth pkss_checker u_pkss_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DELAY_SLOTS     = 4096;
  localparam int EXC_SLOTS       = 2048;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 6;
  localparam int DRAIN_CYCLES    = 10;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int TOTAL_ITEMS     = 1250;
  localparam int CALM_ITEMS      = 200;
  localparam int SHOW_MISMATCHES = 10;
  localparam logic [pkss_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  class string_scoreboard;
    pkss_pkg::sample_t delay_line[DELAY_SLOTS];
    pkss_pkg::sample_t exc_table[EXC_SLOTS];
    bit                exc_loaded[EXC_SLOTS];
    int                wpos;
    int                epos;
    bit                plucking;
    logic [12:0]       dlen_reg;
    logic [15:0]       gain_reg;
    logic [11:0]       elen_reg;
    pkss_pkg::sample_t expected_samples[$];
    int                mismatches;
    int                ticks_seen;
    int                loads_seen;
    int                plucks_seen;
    int                writes_seen;

    function new();
      for (int i = 0; i < DELAY_SLOTS; i++) delay_line[i] = '0;
      for (int i = 0; i < EXC_SLOTS; i++) exc_table[i] = '0;
      wpos     = 0;
      epos     = 0;
      plucking = 0;
      dlen_reg = pkss_pkg::DLEN_RESET;
      gain_reg = pkss_pkg::GAIN_RESET;
      elen_reg = pkss_pkg::ELEN_RESET;
    endfunction

    function int eff_dlen();
      int n;
      n = dlen_reg;
      if (n < 2) n = 2;
      if (n > DELAY_SLOTS) n = DELAY_SLOTS;
      return n;
    endfunction

    function int eff_elen();
      int n;
      n = elen_reg;
      if (n < 1) n = 1;
      if (n > EXC_SLOTS) n = EXC_SLOTS;
      return n;
    endfunction

    // index a tick would read from a never-loaded table entry, or -1
    function int next_read(bit pluck);
      int p;
      p = pluck ? 0 : epos;
      if (!pluck && !plucking) return -1;
      if (p >= eff_elen()) return -1;
      if (!exc_loaded[p]) return p;
      return -1;
    endfunction

    function void note_config(logic [pkss_pkg::CFG_IDX_W-1:0] idx,
                              logic [pkss_pkg::CFG_DATA_W-1:0] data);
      writes_seen++;
      case (idx)
        pkss_pkg::CFG_DELAY_LENGTH: begin
          dlen_reg = data[12:0];
          if (wpos >= eff_dlen()) wpos = 0;
        end
        pkss_pkg::CFG_FEEDBACK_GAIN: gain_reg = data;
        pkss_pkg::CFG_EXC_LENGTH: elen_reg = data[11:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [pkss_pkg::IN_USER_W-1:0] user,
                             logic [pkss_pkg::IN_DATA_W-1:0] data);
      int                dl;
      int                el;
      int                inp;
      int                nxt;
      int                sum;
      int                idx;
      longint            acc;
      longint            y;
      pkss_pkg::sample_t a;
      pkss_pkg::sample_t b;
      dl  = eff_dlen();
      el  = eff_elen();
      inp = 0;
      if (pkss_pkg::req_t'(user[pkss_pkg::USER_REQ_BIT]) == pkss_pkg::REQ_LOAD) begin
        idx = data[pkss_pkg::EXC_IDX_W-1:0];
        exc_table[idx]  = data[pkss_pkg::EXC_VAL_LSB +: pkss_pkg::SAMPLE_W];
        exc_loaded[idx] = 1;
        loads_seen++;
        return;
      end
      ticks_seen++;
      if (user[pkss_pkg::USER_PLUCK_BIT]) begin
        plucking = 1;
        epos     = 0;
        plucks_seen++;
      end
      if (plucking) begin
        if (epos >= el) begin
          plucking = 0;
        end else begin
          inp  = exc_table[epos];
          epos = (epos + 1) & 'hFFF;
          if (epos >= el || epos >= dl) plucking = 0;
        end
      end
      if (wpos >= dl) wpos = 0;
      nxt = wpos + 1;
      if (nxt >= dl) nxt = 0;
      a   = delay_line[wpos];
      b   = delay_line[nxt];
      acc = (longint'(a) + longint'(b)) * longint'(gain_reg);
      y   = acc >>> pkss_pkg::GAIN_SHIFT;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      sum = inp + int'(y);
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      delay_line[wpos] = pkss_pkg::sample_t'(sum);
      wpos = nxt;
      expected_samples.push_back(pkss_pkg::sample_t'(y));
    endfunction

    function void check_result(logic [pkss_pkg::OUT_DATA_W-1:0] data);
      pkss_pkg::sample_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MISMATCHES)
          $display("sample %0d arrived with nothing pending", pkss_pkg::sample_t'(data));
        return;
      end
      want = expected_samples.pop_front();
      if (pkss_pkg::sample_t'(data) !== want) begin
        mismatches++;
        if (mismatches <= SHOW_MISMATCHES)
          $display("sample mismatch: expected %0d got %0d", want, pkss_pkg::sample_t'(data));
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [pkss_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [pkss_pkg::IN_USER_W-1:0]  in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [pkss_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [pkss_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pkss_pkg::CFG_DATA_W-1:0] cfg_data;

  string_scoreboard sb;
  bit idle_en;
  bit stall_en;
  int items_sent;
  int quiet_cycles;
  int out_hold;

  plucked_string_synth #(
    .DELAY_DEPTH(DELAY_SLOTS),
    .EXC_DEPTH  (EXC_SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold   <= out_hold - 1;
      out_tready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      out_hold   <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
      if ((cfg_valid && cfg_ready) || (out_tvalid && out_tready) || (in_tvalid && in_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // enter and leave at a falling edge
  task automatic send_word(pkss_pkg::req_t req, bit pluck,
                           logic [pkss_pkg::EXC_IDX_W-1:0] idx,
                           logic [pkss_pkg::SAMPLE_W-1:0] val);
    logic [pkss_pkg::IN_DATA_W-1:0] d;
    logic [pkss_pkg::IN_USER_W-1:0] u;
    d = '0;
    u = '0;
    d[pkss_pkg::EXC_IDX_W-1:0]                     = idx;
    d[pkss_pkg::EXC_VAL_LSB +: pkss_pkg::SAMPLE_W] = val;
    u[pkss_pkg::USER_REQ_BIT]                      = req;
    u[pkss_pkg::USER_PLUCK_BIT]                    = pluck;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= u;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick(bit pluck);
    int need;
    need = sb.next_read(pluck);
    if (need >= 0)
      send_word(pkss_pkg::REQ_LOAD, 1'($urandom_range(0, 1)), 11'(need), 16'($urandom));
    send_word(pkss_pkg::REQ_TICK, pluck, 11'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [pkss_pkg::CFG_IDX_W-1:0] idx,
                           logic [pkss_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_dlen();
    case ($urandom_range(0, 11))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd4096;
      3: return 16'hFFFF;
      4: return {3'($urandom), 13'($urandom_range(2, 4096))};
      default: return {3'($urandom), 13'($urandom_range(2, 40))};
    endcase
  endfunction

  function automatic logic [15:0] pick_elen();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd2048;
      2: return 16'hFFFF;
      3: return 16'($urandom);
      default: return {4'($urandom), 12'($urandom_range(1, 24))};
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(60000, 65535));
    endcase
  endfunction

  task automatic random_config();
    wait_idle();
    if ($urandom_range(0, 1)) write_reg(pkss_pkg::CFG_DELAY_LENGTH, pick_dlen());
    if ($urandom_range(0, 1)) write_reg(pkss_pkg::CFG_FEEDBACK_GAIN, pick_gain());
    if ($urandom_range(0, 1)) write_reg(pkss_pkg::CFG_EXC_LENGTH, pick_elen());
    if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED_IDX, 16'($urandom));
  endtask

  task automatic play_phase(int n);
    int stop;
    int k;
    stop = items_sent + n;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          k = $urandom_range(1, (sb.eff_elen() < 16) ? sb.eff_elen() : 16);
          for (int i = 0; i < k; i++)
            send_word(pkss_pkg::REQ_LOAD, 1'($urandom_range(0, 1)), 11'(i), 16'($urandom));
          send_tick(1'b1);
          repeat ($urandom_range(2, 30)) send_tick(1'b0);
        end
        6, 7: send_word(pkss_pkg::REQ_LOAD, 1'($urandom_range(0, 1)), 11'($urandom),
                        16'($urandom));
        default: send_tick($urandom_range(0, 3) == 0);
      endcase
    end
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    out_hold   = 0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_en    = 1'b1;
    stall_en   = 1'b1;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // silent string, then table extremes with a stray pluck flag on a load
    send_tick(1'b0);
    send_word(pkss_pkg::REQ_LOAD, 1'b1, 11'd0, 16'h8000);
    send_word(pkss_pkg::REQ_LOAD, 1'b0, 11'd2047, 16'h7FFF);
    send_word(pkss_pkg::REQ_LOAD, 1'b1, 11'h2AA, 16'h5555);
    wait_idle();
    write_reg(pkss_pkg::CFG_FEEDBACK_GAIN, 16'hFFFF);
    write_reg(pkss_pkg::CFG_DELAY_LENGTH, 16'd2);
    send_word(pkss_pkg::REQ_LOAD, 1'b0, 11'd0, 16'h7FFF);
    send_word(pkss_pkg::REQ_LOAD, 1'b0, 11'd1, 16'h7FFF);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    wait_idle();
    write_reg(pkss_pkg::CFG_DELAY_LENGTH, 16'd0);
    repeat (2) send_tick(1'b0);
    wait_idle();
    write_reg(pkss_pkg::CFG_DELAY_LENGTH, 16'd1);
    write_reg(pkss_pkg::CFG_FEEDBACK_GAIN, 16'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_idle();
    write_reg(pkss_pkg::CFG_DELAY_LENGTH, 16'hFFFF);
    write_reg(pkss_pkg::CFG_EXC_LENGTH, 16'd0);
    write_reg(pkss_pkg::CFG_FEEDBACK_GAIN, pkss_pkg::GAIN_RESET);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    wait_idle();
    write_reg(pkss_pkg::CFG_EXC_LENGTH, 16'hFFFF);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    // shrink the table mid-pluck, then pull the write position back
    wait_idle();
    write_reg(pkss_pkg::CFG_EXC_LENGTH, 16'd2);
    send_tick(1'b0);
    wait_idle();
    write_reg(pkss_pkg::CFG_DELAY_LENGTH, 16'd3);
    write_reg(CFG_UNUSED_IDX, 16'h1234);
    repeat (2) send_tick(1'b0);

    while (items_sent < TOTAL_ITEMS - CALM_ITEMS) begin
      random_config();
      play_phase($urandom_range(30, 80));
    end
    idle_en  = 1'b0;
    stall_en = 1'b0;
    while (items_sent < TOTAL_ITEMS) begin
      random_config();
      play_phase($urandom_range(30, 80));
    end
    in_tvalid <= 1'b0;

    while (sb.expected_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("ran %0d ticks (%0d plucks) and %0d loads across %0d register writes",
             sb.ticks_seen, sb.plucks_seen, sb.loads_seen, sb.writes_seen);
    $display("%0d sample mismatches, %0d samples still pending",
             sb.mismatches, sb.expected_samples.size());
    if (sb.mismatches == 0 && sb.expected_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
